/* src/dtsm_pkg.sv */
// shared types and constants for the ducking two-stream mixer
package dtsm_pkg;

  localparam int BATCH_SAMPLES_DEF = 64;
  localparam int SAMPLE_W          = 16;
  localparam int CFG_W             = 16;
  localparam int QUOT_W            = 15;

  localparam logic [15:0]        Q15_ONE = 16'h8000;
  localparam logic signed [15:0] S16_MAX = 16'sh7FFF;
  localparam logic signed [15:0] S16_MIN = 16'sh8000;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_DUCK_GAIN = 1'b0,
    CFG_MEDIA_EN  = 1'b1
  } cfg_idx_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DUCK,
    ST_CHECK,
    ST_DIV,
    ST_STORE,
    ST_EM_RD,
    ST_EM_MUL,
    ST_EM_SUM,
    ST_EM_WAIT
  } state_t;

  // divider handshake toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  // one buffered pair
  typedef struct packed {
    logic                       has_media;
    logic                       has_announce;
    logic signed [SAMPLE_W-1:0] media;
    logic signed [SAMPLE_W-1:0] announce;
  } entry_t;

endpackage

/* src/dtsm_in_if.sv */
// input request channel: media and announcement sample pair
interface dtsm_in_if;
  import dtsm_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] media_sample;
  logic signed [SAMPLE_W-1:0] announce_sample;
  logic                       has_media;
  logic                       has_announce;
  logic                       last_in_batch;

  modport source (
    output valid, media_sample, announce_sample, has_media, has_announce, last_in_batch,
    input  ready
  );
  modport sink (
    input  valid, media_sample, announce_sample, has_media, has_announce, last_in_batch,
    output ready
  );
endinterface

/* src/dtsm_out_if.sv */
// result request channel: mixed sample
interface dtsm_out_if;
  import dtsm_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] mixed_sample;
  logic                       last_of_run;

  modport source (
    output valid, mixed_sample, last_of_run,
    input  ready
  );
  modport sink (
    input  valid, mixed_sample, last_of_run,
    output ready
  );
endinterface

/* src/dtsm_div.sv */
// serial restoring divider for the q15 anti-clip factor, one quotient bit per cycle
module dtsm_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [15:0]                num,
  input  logic [15:0]                den,
  output dtsm_pkg::div_status_t      stat,
  output logic [dtsm_pkg::QUOT_W-1:0] quot
);
  import dtsm_pkg::*;

  localparam int CNT_W = $clog2(QUOT_W + 1);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [15:0]       rem_r;
  logic [15:0]       den_r;
  logic [QUOT_W-1:0] quot_r;

  logic [16:0] trial;
  logic [16:0] diff;
  logic        fits;

  // numerator is below the denominator, so the remainder stays in 16 bits
  assign trial = {rem_r, 1'b0};
  assign diff  = trial - {1'b0, den_r};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(QUOT_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= num;
      den_r  <= den;
      quot_r <= '0;
    end else if (busy_r) begin
      rem_r  <= fits ? diff[15:0] : trial[15:0];
      quot_r <= {quot_r[QUOT_W-2:0], fits};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quot      = quot_r;

endmodule

/* src/ducking_two_stream_audio_mixer.sv */
// top level: batch mixer with media ducking and anti-clip scaling
//
// Accepts one media/announcement pair per request and buffers it in an
// on-chip batch memory of BATCH_SAMPLES entries. Media is ducked by the q15
// gain on arrival (a gain of 32768 or more bypasses it) and is treated as
// absent while media_enable is 0. When both streams are present and their sum
// clips, a 15-step serial divider finds the q15 factor that would just fit,
// and the smallest factor of the batch is kept. On last_in_batch, or when the
// buffer is full, the whole batch is sent out in arrival order: paired media
// is scaled by that factor and the sum saturated, a lone stream passes
// through, an empty pair gives zero; last_of_run marks the final sample.
// A request steps through duck, check and store, with the serial divider run
// when the pair clips; in emit each result is read through the one read port,
// scaled on the single shared multiplier, summed and held over any stall.
// The input is not ready while a request or an emit pass is in progress.
// Configuration writes are meant for idle periods only.
module ducking_two_stream_audio_mixer #(
  parameter int BATCH_SAMPLES = dtsm_pkg::BATCH_SAMPLES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  dtsm_in_if.sink                   in_if,
  dtsm_out_if.source                out_if,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [dtsm_pkg::CFG_W-1:0] cfg_wdata
);
  import dtsm_pkg::*;

  localparam int FILL_W = $clog2(BATCH_SAMPLES + 1);
  localparam int IDX_W  = (BATCH_SAMPLES > 1) ? $clog2(BATCH_SAMPLES) : 1;

  // configuration
  logic [CFG_W-1:0] gain_r;
  logic             media_en_r;

  // sequencer
  state_t state_r, state_nxt;

  // current request
  logic signed [SAMPLE_W-1:0] m_r;
  logic signed [SAMPLE_W-1:0] a_r;
  logic                       hm_r;
  logic                       ha_r;
  logic                       last_r;

  // batch bookkeeping
  logic [FILL_W-1:0] fill_r;
  logic [FILL_W-1:0] fill_inc;
  logic [IDX_W-1:0]  k_r;
  logic [15:0]       min_r;

  // batch buffer
  entry_t mem [BATCH_SAMPLES];
  entry_t rd_r;

  // emit datapath
  logic signed [SAMPLE_W-1:0] scaled_r;
  logic signed [SAMPLE_W-1:0] out_data_r;
  logic                       out_last_r;

  // fsm outputs
  logic in_ready;
  logic out_valid;
  logic div_start;
  logic mem_we;

  // shared multiplier: ducking during ingest, anti-clip scaling during emit
  logic signed [SAMPLE_W-1:0] mul_a;
  logic [14:0]                mul_b;
  logic signed [31:0]         prod;

  assign mul_a = (state_r == ST_DUCK) ? m_r : rd_r.media;
  assign mul_b = (state_r == ST_DUCK) ? gain_r[14:0] : min_r[14:0];
  assign prod  = mul_a * $signed({1'b0, mul_b});

  // clip check on the ducked pair
  logic signed [16:0] pair_sum;
  logic               clip_hi;
  logic               clip_lo;
  logic               clip;
  logic [16:0]        num_wide;
  logic [16:0]        den_wide;

  assign pair_sum = {m_r[15], m_r} + {a_r[15], a_r};
  assign clip_hi  = (pair_sum[16:15] == 2'b01);
  assign clip_lo  = (pair_sum[16:15] == 2'b10);
  assign clip     = hm_r && ha_r && (clip_hi || clip_lo);

  // distance from the announcement to the rail, and media magnitude
  always_comb begin
    num_wide = clip_hi ? ({S16_MAX[15], S16_MAX} - {a_r[15], a_r})
                       : ({a_r[15], a_r} - {S16_MIN[15], S16_MIN});
    den_wide = m_r[15] ? (17'd0 - {m_r[15], m_r}) : {m_r[15], m_r};
  end

  div_status_t       div_stat;
  logic [QUOT_W-1:0] div_quot;

  dtsm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_wide[15:0]),
    .den   (den_wide[15:0]),
    .stat  (div_stat),
    .quot  (div_quot)
  );

  assign fill_inc = fill_r + 1'b1;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:    if (in_if.valid) state_nxt = ST_DUCK;
      ST_DUCK:    state_nxt = ST_CHECK;
      ST_CHECK:   state_nxt = clip ? ST_DIV : ST_STORE;
      ST_DIV:     if (div_stat.done) state_nxt = ST_STORE;
      ST_STORE: begin
        if (last_r || fill_inc == FILL_W'(BATCH_SAMPLES)) state_nxt = ST_EM_RD;
        else state_nxt = ST_IDLE;
      end
      ST_EM_RD:   state_nxt = ST_EM_MUL;
      ST_EM_MUL:  state_nxt = ST_EM_SUM;
      ST_EM_SUM:  state_nxt = ST_EM_WAIT;
      ST_EM_WAIT: begin
        if (out_if.ready) state_nxt = out_last_r ? ST_IDLE : ST_EM_RD;
      end
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    div_start = 1'b0;
    mem_we    = 1'b0;
    unique case (state_r)
      ST_IDLE:    in_ready  = 1'b1;
      ST_CHECK:   div_start = clip;
      ST_STORE:   mem_we    = 1'b1;
      ST_EM_WAIT: out_valid = 1'b1;
      default: ;
    endcase
  end

  assign in_if.ready         = in_ready;
  assign out_if.valid        = out_valid;
  assign out_if.mixed_sample = out_data_r;
  assign out_if.last_of_run  = out_last_r;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      gain_r     <= Q15_ONE;
      media_en_r <= 1'b1;
      fill_r     <= '0;
      min_r      <= Q15_ONE;
      k_r        <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_DUCK_GAIN: gain_r     <= cfg_wdata;
          CFG_MEDIA_EN:  media_en_r <= cfg_wdata[0];
          default: ;
        endcase
      end
      // keep the smallest clip factor of the batch
      if (state_r == ST_DIV && div_stat.done && {1'b0, div_quot} < min_r) begin
        min_r <= {1'b0, div_quot};
      end
      if (state_r == ST_STORE) begin
        fill_r <= fill_inc;
        k_r    <= '0;
      end
      if (state_r == ST_EM_WAIT && out_if.ready) begin
        if (out_last_r) begin
          fill_r <= '0;
          min_r  <= Q15_ONE;
        end else begin
          k_r <= k_r + 1'b1;
        end
      end
    end
  end

  // request capture and ducking
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_if.valid) begin
      m_r    <= in_if.media_sample;
      a_r    <= in_if.announce_sample;
      hm_r   <= in_if.has_media & media_en_r;
      ha_r   <= in_if.has_announce;
      last_r <= in_if.last_in_batch;
    end else if (state_r == ST_DUCK && hm_r && !gain_r[15]) begin
      // floor of the q15 product
      m_r <= prod[30:15];
    end
  end

  // batch buffer: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[fill_r[IDX_W-1:0]] <= '{has_media: hm_r, has_announce: ha_r,
                                  media: m_r, announce: a_r};
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_EM_RD) begin
      rd_r <= mem[k_r];
    end
  end

  // emit datapath
  logic signed [16:0] mix_sum;

  assign mix_sum = {scaled_r[15], scaled_r} + {rd_r.announce[15], rd_r.announce};

  always_ff @(posedge clk) begin
    if (state_r == ST_EM_MUL) begin
      scaled_r <= min_r[15] ? rd_r.media : prod[30:15];
    end
    if (state_r == ST_EM_SUM) begin
      out_last_r <= (FILL_W'(k_r) + 1'b1) == fill_r;
      case ({rd_r.has_media, rd_r.has_announce})
        2'b11: begin
          if (mix_sum[16:15] == 2'b01)      out_data_r <= S16_MAX;
          else if (mix_sum[16:15] == 2'b10) out_data_r <= S16_MIN;
          else                              out_data_r <= mix_sum[15:0];
        end
        2'b10:   out_data_r <= rd_r.media;
        2'b01:   out_data_r <= rd_r.announce;
        default: out_data_r <= '0;
      endcase
    end
  end

  // checks
  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while a result is pending");

  a_min_range: assert property (@(posedge clk) disable iff (!rst_n)
    min_r <= Q15_ONE)
    else $error("clip factor above unity");

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(BATCH_SAMPLES))
    else $error("batch fill beyond buffer depth");

  a_batch_close: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_if.ready && out_last_r) |=> (fill_r == '0 && min_r == Q15_ONE))
    else $error("batch state not cleared after last result");

  a_div_alive: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (div_stat.busy || div_stat.done))
    else $error("waiting on an idle divider");

endmodule
